### sv/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and symbol helpers shared by the Base64 codec modules.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic       MODE_ENC = 1'b0;
    localparam logic       MODE_DEC = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       out_last;
        logic       error;
    } t_out;

    // one queued job: a 4-character encode group or one decode result
    typedef struct packed {
        logic        dec;
        logic [23:0] grp;
        logic [2:0]  nsym;
        logic        last;
        logic        has;
        logic        err;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sym;

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic t_sym char_sym(input logic [7:0] c);
        t_sym s;
        s.ok  = 1'b1;
        s.val = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.val = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.val = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.val = 6'd62;
        end else if (c == 8'h2F) begin
            s.val = 6'd63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

endpackage

### sv/b64sc_front.sv
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input words, keeps message state and pushes result jobs.
// ----------------------------------------------------------------------------
module b64sc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  b64sc_pkg::t_in    i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output b64sc_pkg::t_job   o_job
);
    import b64sc_pkg::*;

    logic        r_mode;
    logic [15:0] r_held, n_held;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [5:0]  r_lo, n_lo;
    logic [2:0]  r_bcnt, n_bcnt;
    logic        r_pad, n_pad;
    logic        r_err, n_err;

    logic        acc;
    logic        emit;
    logic [7:0]  c;
    t_sym        sym;
    t_job        job;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;
    assign c       = i_in.in_byte;
    assign sym     = char_sym(c);

    always_comb begin
        n_held = r_held;
        n_hcnt = r_hcnt;
        n_lo   = r_lo;
        n_bcnt = r_bcnt;
        n_pad  = r_pad;
        n_err  = r_err;
        emit   = 1'b0;
        job    = '0;
        job.dec  = r_mode;
        job.last = i_in.last;
        if (r_mode == MODE_ENC) begin
            emit = 1'b1;
            if (r_hcnt >= 2'd2) begin
                job.grp  = {r_held, c};
                job.nsym = 3'd4;
                n_held   = '0;
                n_hcnt   = '0;
            end else if (i_in.last) begin
                if (r_hcnt == 2'd1) begin
                    job.grp  = {r_held[7:0], c, 8'h00};
                    job.nsym = 3'd3;
                end else begin
                    job.grp  = {c, 16'h0000};
                    job.nsym = 3'd2;
                end
            end else begin
                emit   = 1'b0;
                n_held = {r_held[7:0], c};
                n_hcnt = r_hcnt + 2'd1;
            end
        end else begin
            if (!r_err) begin
                if (c == PAD_CHAR) begin
                    n_pad = 1'b1;
                end else if (r_pad) begin
                    n_err = 1'b1;
                end else if (!is_space(c)) begin
                    if (!sym.ok) begin
                        n_err = 1'b1;
                    end else begin
                        case (r_bcnt)
                            3'd2: begin
                                job.has      = 1'b1;
                                job.grp[7:0] = {r_lo[1:0], sym.val};
                                n_lo         = '0;
                                n_bcnt       = 3'd0;
                            end
                            3'd4: begin
                                job.has      = 1'b1;
                                job.grp[7:0] = {r_lo[3:0], sym.val[5:2]};
                                n_lo         = {4'b0000, sym.val[1:0]};
                                n_bcnt       = 3'd2;
                            end
                            3'd6: begin
                                job.has      = 1'b1;
                                job.grp[7:0] = {r_lo[5:0], sym.val[5:4]};
                                n_lo         = {2'b00, sym.val[3:0]};
                                n_bcnt       = 3'd4;
                            end
                            default: begin
                                n_lo   = sym.val;
                                n_bcnt = 3'd6;
                            end
                        endcase
                    end
                end
            end
            job.err = n_err;
            emit    = job.has || i_in.last;
        end
        if (i_in.last) begin
            n_held = '0;
            n_hcnt = '0;
            n_lo   = '0;
            n_bcnt = '0;
            n_pad  = 1'b0;
            n_err  = 1'b0;
        end
    end

    assign o_push = acc && emit;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
            r_held <= '0;
            r_hcnt <= '0;
            r_lo   <= '0;
            r_bcnt <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
            r_held <= '0;
            r_hcnt <= '0;
            r_lo   <= '0;
            r_bcnt <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (acc) begin
            r_held <= n_held;
            r_hcnt <= n_hcnt;
            r_lo   <= n_lo;
            r_bcnt <= n_bcnt;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

endmodule

### sv/b64sc_queue.sv
// ----------------------------------------------------------------------------
// b64sc_queue
// Small job FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module b64sc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64sc_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output b64sc_pkg::t_job   o_job
);
    import b64sc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### sv/b64sc_back.sv
// ----------------------------------------------------------------------------
// b64sc_back
// Expands queued jobs into output words, one per cycle while the output is free
// and the queue is not empty, into the output register.
// ----------------------------------------------------------------------------
module b64sc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  b64sc_pkg::t_job   i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output b64sc_pkg::t_out   o_out
);
    import b64sc_pkg::*;

    logic       r_valid;
    t_out       r_out, n_out;
    logic [1:0] r_idx;
    logic       out_free;
    logic       step;
    logic [5:0] sv6;

    assign out_free = !r_valid || i_ready;
    assign step     = out_free && !i_empty;
    assign o_pop    = step && (i_job.dec || r_idx == 2'd3);

    always_comb begin
        case (r_idx)
            2'd0:    sv6 = i_job.grp[23:18];
            2'd1:    sv6 = i_job.grp[17:12];
            2'd2:    sv6 = i_job.grp[11:6];
            default: sv6 = i_job.grp[5:0];
        endcase
        n_out = '0;
        if (i_job.dec) begin
            n_out.out_byte = i_job.has ? i_job.grp[7:0] : 8'h00;
            n_out.has_data = i_job.has;
            n_out.out_last = i_job.last;
            n_out.error    = i_job.err;
        end else begin
            n_out.out_byte = ({1'b0, r_idx} < i_job.nsym) ? sym_char(sv6) : PAD_CHAR;
            n_out.has_data = 1'b1;
            n_out.out_last = i_job.last && (r_idx == 2'd3);
            n_out.error    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (out_free) begin
                r_valid <= !i_empty;
            end
            if (o_pop) begin
                r_idx <= '0;
            end else if (step) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

### sv/base64_stream_codec_top.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// The first result passes through the job queue into the output register.
// Throughput: one result per cycle from the back end while the output is not
// stalled; encode emits four characters per group of up to 3 bytes.
// Reset: synchronous; mode returns to encode, message state, queue and
// output valid are cleared.
// ----------------------------------------------------------------------------
module base64_stream_codec_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  b64sc_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output b64sc_pkg::t_out   o_out
);
    import b64sc_pkg::*;

    logic q_full, q_empty, push, pop;
    t_job job_in, job_out;

    b64sc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job_in)
    );

    b64sc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    b64sc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_out   (o_out)
    );

endmodule
